FILE: src/yuv420_to_rgb_downscaler_top_defines.svh
// Assertion macros used by the port-level checker of the YUV to RGB downscaler.
`ifndef YUV420_TO_RGB_DOWNSCALER_TOP_DEFINES_SVH
`define YUV420_TO_RGB_DOWNSCALER_TOP_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define YRD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("yrd assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define YRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("yrd assertion failed");

`endif

FILE: src/yrd_pkg.sv
// Types, constants and helpers shared by the YUV to RGB downscaler.
`default_nettype none

package yrd_pkg;

  // Geometry
  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_W     = $clog2(MAX_DIM + 1);
  localparam int unsigned POS_W     = $clog2(MAX_DIM);
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned STEP_W    = 29;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned TGT_INT_W = STEP_W - FRAC_W;
  localparam int unsigned CMP_W     = (POS_W > TGT_INT_W) ? POS_W : TGT_INT_W;
  localparam logic [STEP_W-1:0] ONE_Q16 = STEP_W'(65536);

  // Configuration port
  localparam int unsigned IDX_W = 3;
  localparam int unsigned CFG_W = STEP_W;
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_X_STEP     = 3'd4;
  localparam logic [IDX_W-1:0] REG_Y_STEP     = 3'd5;

  localparam int unsigned REG_DIM_W = 13;
  localparam logic [REG_DIM_W-1:0] RST_SRC_WIDTH  = 13'd640;
  localparam logic [REG_DIM_W-1:0] RST_SRC_HEIGHT = 13'd480;
  localparam logic [REG_DIM_W-1:0] RST_DST_WIDTH  = 13'd640;
  localparam logic [REG_DIM_W-1:0] RST_DST_HEIGHT = 13'd480;

  // Q13 color coefficients
  localparam int unsigned Q_SHIFT = 13;
  localparam logic signed [15:0] COEF_RV = 16'sd11277;
  localparam logic signed [15:0] COEF_GU = 16'sd2765;
  localparam logic signed [15:0] COEF_GV = 16'sd5726;
  localparam logic signed [15:0] COEF_BU = 16'sd14216;
  localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;
  localparam logic signed [11:0] PIX_MAX = 12'sd255;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic               frame_done;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [DIM_W-1:0]  src_width;
    logic [DIM_W-1:0]  src_height;
    logic [DIM_W-1:0]  dst_width;
    logic [DIM_W-1:0]  dst_height;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
  } cfg_t;

  // Destination position tag of a selected pixel
  typedef struct packed {
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic               frame_done;
  } pos_t;

  // Clamp a signed component to 0..255
  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    logic [7:0] res;
    if (v < 0) begin
      res = 8'd0;
    end else if (v > PIX_MAX) begin
      res = 8'd255;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: src/yuv420_to_rgb_downscaler_top.sv
// Top level of the YUV 4:2:0 to RGB converter with nearest-neighbor downscale.
//
// Input channel: one source pixel word per accepted cycle (in_valid_i high,
// in_stall_o low), in raster order, luma plus the chroma pair of its 2x2 block.
// Output channel: one RGB word per selected pixel, tagged with destination
// column, row and a frame_done mark on the last destination pixel.
// Pixels that the scaler skips produce no output word.
// A selected pixel passes the selection register, then conversion into the
// output register, before it appears on out_valid_o.
// Throughput: one source pixel per cycle while in_stall_o is low, set by the
// counter update loop that decides each pixel in the cycle it is accepted.
// Out_stall_i holds the output word; the selection register still takes words
// until a selected one lands, then in_stall_o rises until the output drains.
// Reset clears the raster counters and both pipeline stages and loads the
// default sizes (640x480 to 640x480, unit steps). Registers must be written
// through cfg_we_i only while the block is idle; nothing enforces it.
`default_nettype none

module yuv420_to_rgb_downscaler_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  yrd_pkg::pix_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output yrd_pkg::pix_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [yrd_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [yrd_pkg::CFG_W-1:0] cfg_data_i
);
  import yrd_pkg::*;

  cfg_t     cfg;
  pos_t     scan_pos;
  logic     scan_hit;
  rgb_t     rgb;
  logic     out_ready, s1_ready, in_acc;
  logic     s1_valid_q, out_valid_q;
  pix_in_t  s1_pix_q;
  pos_t     s1_pos_q;
  pix_out_t out_data_q;

  yrd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  yrd_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (in_acc),
    .cfg_i  (cfg),
    .hit_o  (scan_hit),
    .pos_o  (scan_pos)
  );

  yrd_csc u_csc (
    .pix_i (s1_pix_q),
    .rgb_o (rgb)
  );

  // Handshake
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_ready   = !s1_valid_q || out_ready;
  assign in_stall_o = !s1_ready;
  assign in_acc     = in_valid_i && s1_ready;

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_acc && scan_hit;
      end
      if (out_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q <= in_data_i;
      s1_pos_q <= scan_pos;
    end
    if (out_ready && s1_valid_q) begin
      out_data_q.red        <= rgb.red;
      out_data_q.green      <= rgb.green;
      out_data_q.blue       <= rgb.blue;
      out_data_q.dest_x     <= s1_pos_q.dest_x;
      out_data_q.dest_y     <= s1_pos_q.dest_y;
      out_data_q.frame_done <= s1_pos_q.frame_done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: src/yrd_cfg.sv
// Configuration register file with clamping of sizes and steps.
`default_nettype none

module yrd_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [yrd_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [yrd_pkg::CFG_W-1:0] cfg_data_i,
  output yrd_pkg::cfg_t             cfg_o
);
  import yrd_pkg::*;

  logic [REG_DIM_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [STEP_W-1:0]    x_step_q, y_step_q;

  // Size used as 1..MAX_DIM
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [REG_DIM_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  // Step below one is taken as one
  function automatic logic [STEP_W-1:0] eff_step(input logic [STEP_W-1:0] v);
    return (v < ONE_Q16) ? ONE_Q16 : v;
  endfunction

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= RST_SRC_WIDTH;
      src_height_q <= RST_SRC_HEIGHT;
      dst_width_q  <= RST_DST_WIDTH;
      dst_height_q <= RST_DST_HEIGHT;
      x_step_q     <= ONE_Q16;
      y_step_q     <= ONE_Q16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[REG_DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i[REG_DIM_W-1:0];
        REG_DST_WIDTH:  dst_width_q  <= cfg_data_i[REG_DIM_W-1:0];
        REG_DST_HEIGHT: dst_height_q <= cfg_data_i[REG_DIM_W-1:0];
        REG_X_STEP:     x_step_q     <= cfg_data_i[STEP_W-1:0];
        REG_Y_STEP:     y_step_q     <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective values
  always_comb begin
    cfg_o.src_width  = clamp_dim(src_width_q);
    cfg_o.src_height = clamp_dim(src_height_q);
    cfg_o.dst_width  = clamp_dim(dst_width_q);
    cfg_o.dst_height = clamp_dim(dst_height_q);
    cfg_o.x_step     = eff_step(x_step_q);
    cfg_o.y_step     = eff_step(y_step_q);
  end

endmodule

`default_nettype wire

FILE: src/yrd_scan.sv
// Raster position counters and nearest-neighbor pixel selection.
`default_nettype none

module yrd_scan (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  yrd_pkg::cfg_t cfg_i,
  output logic          hit_o,
  output yrd_pkg::pos_t pos_o
);
  import yrd_pkg::*;

  logic [POS_W-1:0]  src_col_q, src_col_d, src_row_q, src_row_d;
  logic [DIM_W-1:0]  dst_col_q, dst_col_d, dst_row_q, dst_row_d;
  logic [STEP_W-1:0] col_tgt_q, col_tgt_d, row_tgt_q, row_tgt_d;
  logic              row_hit, col_hit, row_end, frame_end;
  logic [DIM_W-1:0]  col_inc, row_inc;

  // Target plus step, saturating at all ones
  function automatic logic [STEP_W-1:0] sat_add(input logic [STEP_W-1:0] a,
                                                input logic [STEP_W-1:0] b);
    logic [STEP_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[STEP_W] ? {STEP_W{1'b1}} : sum[STEP_W-1:0];
  endfunction

  // Selection against the integer part of the targets
  always_comb begin
    row_hit = (dst_row_q < cfg_i.dst_height) &&
              (CMP_W'(src_row_q) == CMP_W'(row_tgt_q[STEP_W-1:FRAC_W]));
    col_hit = (dst_col_q < cfg_i.dst_width) &&
              (CMP_W'(src_col_q) == CMP_W'(col_tgt_q[STEP_W-1:FRAC_W]));
    col_inc = dst_col_q + DIM_W'(1);
    row_inc = dst_row_q + DIM_W'(1);
    row_end   = (DIM_W'(src_col_q) + DIM_W'(1)) >= cfg_i.src_width;
    frame_end = (DIM_W'(src_row_q) + DIM_W'(1)) >= cfg_i.src_height;
  end

  assign hit_o            = row_hit && col_hit;
  assign pos_o.dest_x     = COORD_W'(dst_col_q);
  assign pos_o.dest_y     = COORD_W'(dst_row_q);
  assign pos_o.frame_done = (col_inc == cfg_i.dst_width) && (row_inc == cfg_i.dst_height);

  // Next position
  always_comb begin
    src_col_d = src_col_q;
    src_row_d = src_row_q;
    dst_col_d = dst_col_q;
    dst_row_d = dst_row_q;
    col_tgt_d = col_tgt_q;
    row_tgt_d = row_tgt_q;
    if (adv_i) begin
      if (col_hit) begin
        dst_col_d = col_inc;
        col_tgt_d = sat_add(col_tgt_q, cfg_i.x_step);
      end
      if (row_end) begin
        src_col_d = '0;
        dst_col_d = '0;
        col_tgt_d = '0;
        if (row_hit) begin
          dst_row_d = row_inc;
          row_tgt_d = sat_add(row_tgt_q, cfg_i.y_step);
        end
        if (frame_end) begin
          src_row_d = '0;
          dst_row_d = '0;
          row_tgt_d = '0;
        end else begin
          src_row_d = src_row_q + POS_W'(1);
        end
      end else begin
        src_col_d = src_col_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_col_q <= '0;
      src_row_q <= '0;
      dst_col_q <= '0;
      dst_row_q <= '0;
      col_tgt_q <= '0;
      row_tgt_q <= '0;
    end else begin
      src_col_q <= src_col_d;
      src_row_q <= src_row_d;
      dst_col_q <= dst_col_d;
      dst_row_q <= dst_row_d;
      col_tgt_q <= col_tgt_d;
      row_tgt_q <= row_tgt_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/yrd_csc.sv
// YUV to RGB color conversion with Q13 constant coefficients.
`default_nettype none

module yrd_csc (
  input  yrd_pkg::pix_in_t pix_i,
  output yrd_pkg::rgb_t    rgb_o
);
  import yrd_pkg::*;

  logic signed [8:0]  u, v;
  logic signed [23:0] r_prod, g_prod, b_prod;
  logic signed [11:0] y_ext, r_val, g_val, b_val;

  // Remove chroma offset
  assign u = $signed({1'b0, pix_i.chroma_blue}) - CHROMA_OFS;
  assign v = $signed({1'b0, pix_i.chroma_red}) - CHROMA_OFS;

  // Constant products
  assign r_prod = COEF_RV * v;
  assign g_prod = COEF_GU * u + COEF_GV * v;
  assign b_prod = COEF_BU * u;

  // Floor by arithmetic shift, then add luma
  assign y_ext = $signed({4'b0000, pix_i.luma});
  assign r_val = y_ext + 12'(r_prod >>> Q_SHIFT);
  assign g_val = y_ext - 12'(g_prod >>> Q_SHIFT);
  assign b_val = y_ext + 12'(b_prod >>> Q_SHIFT);

  assign rgb_o.red   = clamp8(r_val);
  assign rgb_o.green = clamp8(g_val);
  assign rgb_o.blue  = clamp8(b_val);

endmodule

`default_nettype wire

FILE: src/yrd_checker.sv
// Port-level checker for the downscaler top, bound to it below.
`default_nettype none
`include "yuv420_to_rgb_downscaler_top_defines.svh"

module yrd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input yrd_pkg::pix_out_t out_data_o
);

  // Stalled output word holds
  `YRD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Input only stalls when the output is blocked
  `YRD_ASSERT_NOW(a_no_stall_free, clk_i, rst_ni, !out_stall_i, !in_stall_o)

  // Input stall means a word sits in the output register
  `YRD_ASSERT_NOW(a_stall_full, clk_i, rst_ni, in_stall_o, out_valid_o)

  // Free output with no new words drains the selection and output registers in turn
  `YRD_ASSERT_NEXT(a_drain, clk_i, rst_ni, (!(in_valid_i && !in_stall_o) && !out_stall_i) ##1 (!(in_valid_i && !in_stall_o) && !out_stall_i), !out_valid_o)

endmodule

bind yuv420_to_rgb_downscaler_top yrd_checker u_yrd_checker (.*);

`default_nettype wire

FILE: sim/yuv420_to_rgb_downscaler_checker.sv
// Checker for the YUV to RGB downscaler: predicts the scaled RGB stream and compares it.
module yuv420_to_rgb_downscaler_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  yrd_pkg::pix_in_t          in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  yrd_pkg::pix_out_t         out_data_i,
  input  logic                      cfg_we_i,
  input  logic [yrd_pkg::IDX_W-1:0] cfg_index_i,
  input  logic [yrd_pkg::CFG_W-1:0] cfg_data_i,
  output int unsigned               pending_o,
  output int unsigned               errors_o
);
  import yrd_pkg::*;

  // Q13 conversion coefficients
  localparam int K_RED_V   = 11277;
  localparam int K_GREEN_U = 2765;
  localparam int K_GREEN_V = 5726;
  localparam int K_BLUE_U  = 14216;
  localparam int CHROMA_ZERO = 128;

  // Shadow of the size and step registers
  logic [REG_DIM_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [STEP_W-1:0]    x_step_q, y_step_q;

  // Raster position and running Q16 targets
  logic [POS_W-1:0]     src_col, src_row;
  logic [REG_DIM_W-1:0] dst_col, dst_row;
  logic [STEP_W-1:0]    col_target, row_target;

  pix_out_t    pixels_due[$];
  int unsigned mismatches;

  // Width/height registers act as clamped to 1..MAX_DIM
  function automatic logic [REG_DIM_W-1:0] eff_dim(input logic [REG_DIM_W-1:0] d);
    if (d == '0) return REG_DIM_W'(1);
    if (d > MAX_DIM) return REG_DIM_W'(MAX_DIM);
    return d;
  endfunction

  // Step floor of 1.0, saturating add at the top of the target range
  function automatic logic [STEP_W-1:0] advance_target(input logic [STEP_W-1:0] tgt,
                                                       input logic [STEP_W-1:0] step);
    logic [STEP_W:0]   sum;
    logic [STEP_W-1:0] inc;
    inc = (step < ONE_Q16) ? ONE_Q16 : step;
    sum = {1'b0, tgt} + {1'b0, inc};
    return sum[STEP_W] ? '1 : sum[STEP_W-1:0];
  endfunction

  function automatic logic [7:0] to_byte(input int c);
    if (c < 0) return 8'd0;
    if (c > 255) return 8'd255;
    return c[7:0];
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    pix_out_t             want;
    logic [REG_DIM_W-1:0] sw, sh, dw, dh;
    logic                 row_hit, col_hit;
    int                   y, u, v;
    if (!rst_ni) begin
      src_width_q  = RST_SRC_WIDTH;
      src_height_q = RST_SRC_HEIGHT;
      dst_width_q  = RST_DST_WIDTH;
      dst_height_q = RST_DST_HEIGHT;
      x_step_q     = ONE_Q16;
      y_step_q     = ONE_Q16;
      src_col      = '0;
      src_row      = '0;
      dst_col      = '0;
      dst_row      = '0;
      col_target   = '0;
      row_target   = '0;
      pixels_due.delete();
      mismatches   = 0;
      pending_o   <= 0;
      errors_o    <= 0;
    end else begin
      // Output side first: a word leaving now can't come from the word entering now
      if (out_valid_i && !out_stall_i) begin
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected output word, expected none, actual %h",
                   $time, out_data_i);
          mismatches++;
        end else begin
          want = pixels_due.pop_front();
          compare_field("red", want.red, out_data_i.red);
          compare_field("green", want.green, out_data_i.green);
          compare_field("blue", want.blue, out_data_i.blue);
          compare_field("dest_x", want.dest_x, out_data_i.dest_x);
          compare_field("dest_y", want.dest_y, out_data_i.dest_y);
          compare_field("frame_done", want.frame_done, out_data_i.frame_done);
        end
      end

      // Register writes; indexes past the step registers are dropped
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SRC_WIDTH:  src_width_q  = cfg_data_i[REG_DIM_W-1:0];
          REG_SRC_HEIGHT: src_height_q = cfg_data_i[REG_DIM_W-1:0];
          REG_DST_WIDTH:  dst_width_q  = cfg_data_i[REG_DIM_W-1:0];
          REG_DST_HEIGHT: dst_height_q = cfg_data_i[REG_DIM_W-1:0];
          REG_X_STEP:     x_step_q     = cfg_data_i[STEP_W-1:0];
          REG_Y_STEP:     y_step_q     = cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end

      // Source pixel: decide selection, convert, move the raster on
      if (in_valid_i && !in_stall_i) begin
        sw = eff_dim(src_width_q);
        sh = eff_dim(src_height_q);
        dw = eff_dim(dst_width_q);
        dh = eff_dim(dst_height_q);
        row_hit = (dst_row < dh) && (src_row == row_target[STEP_W-1:FRAC_W]);
        col_hit = (dst_col < dw) && (src_col == col_target[STEP_W-1:FRAC_W]);

        if (row_hit && col_hit) begin
          y = int'(in_data_i.luma);
          u = int'(in_data_i.chroma_blue) - CHROMA_ZERO;
          v = int'(in_data_i.chroma_red) - CHROMA_ZERO;
          want.red        = to_byte(y + ((K_RED_V * v) >>> Q_SHIFT));
          want.green      = to_byte(y - ((K_GREEN_U * u + K_GREEN_V * v) >>> Q_SHIFT));
          want.blue       = to_byte(y + ((K_BLUE_U * u) >>> Q_SHIFT));
          want.dest_x     = dst_col[COORD_W-1:0];
          want.dest_y     = dst_row[COORD_W-1:0];
          want.frame_done = (dst_col + 1'b1 == dw) && (dst_row + 1'b1 == dh);
          pixels_due.push_back(want);
        end

        if (col_hit) begin
          dst_col++;
          col_target = advance_target(col_target, x_step_q);
        end

        if (src_col + 1 >= sw) begin
          src_col    = '0;
          dst_col    = '0;
          col_target = '0;
          if (row_hit) begin
            dst_row++;
            row_target = advance_target(row_target, y_step_q);
          end
          if (src_row + 1 >= sh) begin
            src_row    = '0;
            dst_row    = '0;
            row_target = '0;
          end else begin
            src_row++;
          end
        end else begin
          src_col++;
        end
      end

      pending_o <= pixels_due.size();
      errors_o  <= mismatches;
    end
  end

endmodule

FILE: sim/yuv420_to_rgb_downscaler_top_tb.sv
// Stimulus and verdict for the YUV to RGB downscaler; checking lives in the checker.
module yuv420_to_rgb_downscaler_top_tb;
  import yrd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned RANDOM_PIXELS = 640;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned TARGET_TOP    = 32'h1FFF_FFFF;

  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  pix_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  pix_out_t          out_data;
  logic              cfg_we    = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data  = '0;

  int unsigned pending;
  int unsigned errors;
  int unsigned cycle_count = 0;
  int unsigned idle_pct    = 0;
  int unsigned stall_pct   = 0;
  int unsigned phase_count = 0;
  pix_in_t     directed_words[$];

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  yuv420_to_rgb_downscaler_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  yuv420_to_rgb_downscaler_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // Receiver back-pressure
  always @(posedge clk_i) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("yuv420_to_rgb_downscaler_top test failed");
      $finish;
    end
  end

  function automatic int unsigned frame_dim(input int unsigned d);
    logic [REG_DIM_W-1:0] v;
    v = d[REG_DIM_W-1:0];
    if (v == '0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // Random byte, leaning on the extremes
  function automatic logic [7:0] pick_byte();
    int unsigned roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 8'd0;
    if (roll == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(value);
    @(posedge clk_i);
  endtask

  // One word on the input channel, with optional idle cycles ahead of it
  task automatic send_word(input pix_in_t word);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Program all registers, stream whole frames, let the pipeline empty
  task automatic run_phase(input int unsigned sw, input int unsigned sh,
                           input int unsigned dw, input int unsigned dh,
                           input int unsigned xs, input int unsigned ys,
                           input int unsigned frames);
    int unsigned total;
    pix_in_t     word;
    flow_t       flow;
    total = frames * frame_dim(sw) * frame_dim(sh);
    flow  = flow_t'(phase_count % 4);
    phase_count++;
    case (flow)
      FLOW_FREE:        begin idle_pct = 0;  stall_pct <= 0;  end
      FLOW_SEND_GAPS:   begin idle_pct = 74; stall_pct <= 0;  end
      FLOW_RECV_STALLS: begin idle_pct = 0;  stall_pct <= 74; end
      default:          begin idle_pct = 30; stall_pct <= 30; end
    endcase
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    cfg_we <= 1'b0;
    repeat (total) begin
      if (directed_words.size() != 0) begin
        word = directed_words.pop_front();
      end else begin
        word.luma        = pick_byte();
        word.chroma_blue = pick_byte();
        word.chroma_red  = pick_byte();
      end
      send_word(word);
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  initial begin : stimulus
    logic [7:0]  levels [3];
    int unsigned sw, sh, dw, dh, xs, ys, shape, frames;
    int unsigned random_pixels;
    levels = '{8'd0, 8'd128, 8'd255};
    random_pixels = 0;

    // Corner pixel values: every luma/chroma extreme, plus values next to the offset
    foreach (levels[i]) begin
      foreach (levels[j]) begin
        directed_words.push_back('{8'd0, levels[i], levels[j]});
        directed_words.push_back('{8'd255, levels[i], levels[j]});
      end
    end
    directed_words.push_back('{8'd16, 8'd127, 8'd129});
    directed_words.push_back('{8'd235, 8'd129, 8'd127});
    directed_words.push_back('{8'd128, 8'd1, 8'd254});
    directed_words.push_back('{8'd128, 8'd254, 8'd1});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 1:1 copy, step of zero, zero sizes, destination never filled
    run_phase(4, 2, 4, 2, 65536, 65536, 1);
    run_phase(3, 3, 2, 2, 0, 0, 1);
    run_phase(0, 0, 0, 0, 1, 65535, 1);
    run_phase(2, 2, 8191, 8191, 65536, 65536, 1);

    // Saturating targets: only the first column and row are ever hit
    run_phase(8, 4, 3, 2, TARGET_TOP, 268435456, 1);

    // Long row and tall column, each kept one pixel thin
    run_phase(320, 1, 160, 1, 131072, 65536, 1);
    run_phase(1, 240, 1, 80, 65536, 196608, 1);

    // Random small frames, mostly consistent steps
    while (random_pixels < RANDOM_PIXELS) begin
      sw    = $urandom_range(1, 16);
      sh    = $urandom_range(1, 12);
      shape = $urandom_range(0, 9);
      if (shape == 7) begin
        // destination larger than the source
        dw = $urandom_range(1, sw + 3);
        dh = $urandom_range(1, sh + 3);
      end else begin
        dw = $urandom_range(1, sw);
        dh = $urandom_range(1, sh);
      end
      xs = (sw << 16) / dw;
      ys = (sh << 16) / dh;
      if (shape == 8) begin
        xs = $urandom_range(0, 4 * 65536);
        ys = $urandom_range(0, 4 * 65536);
      end else if (shape == 9) begin
        xs = $urandom_range(65536, TARGET_TOP);
        ys = $urandom_range(65536, TARGET_TOP);
      end
      frames = $urandom_range(1, 3);
      run_phase(sw, sh, dw, dh, xs, ys, frames);
      random_pixels += frames * sw * sh;
    end

    wait_drained();
    if (errors == 0 && pending == 0) begin
      $display("yuv420_to_rgb_downscaler_top test passed");
    end else begin
      $display("yuv420_to_rgb_downscaler_top test failed");
    end
    $finish;
  end

endmodule
